FILE: src/mfh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfh_pkg: shared types for the mqtt fixed header deframer
// Phase, role and error codes, the framing state record and the per-byte
// result record.
// ---------------------------------------------------------------------------
package mfh_pkg;

	localparam int LEN_W  = 28;
	localparam int CNT_W  = 3;
	localparam int HDR_W  = 3;

	localparam logic [3:0] TYPE_RESERVED_LO = 4'h0;
	localparam logic [3:0] TYPE_RESERVED_HI = 4'hF;

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_LEN,
		PH_PAY,
		PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_TYPE,
		ROLE_LEN,
		ROLE_PAY,
		ROLE_DISCARD
	} role_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_TOO_LONG,
		ERR_RESERVED
	} err_t;

	typedef struct packed {
		phase_t             phase;
		logic [7:0]         type_flags;
		logic [LEN_W-1:0]   length_accum;
		logic [CNT_W-1:0]   length_byte_count;
		logic [LEN_W-1:0]   payload_left;
		err_t               error;
	} mfh_state_t;

	typedef struct packed {
		logic [7:0]         data_byte;
		role_t              role;
		logic               done;
		logic [7:0]         type_flags;
		logic [LEN_W-1:0]   length;
		logic [HDR_W-1:0]   header_size;
		err_t               error;
	} mfh_result_t;

	localparam mfh_state_t STATE_RESET = '{
		phase:             PH_TYPE,
		type_flags:        8'd0,
		length_accum:      '0,
		length_byte_count: '0,
		payload_left:      '0,
		error:             ERR_NONE
	};

	function automatic logic type_reserved(input logic [3:0] ptype);
		return (ptype == TYPE_RESERVED_LO) || (ptype == TYPE_RESERVED_HI);
	endfunction

endpackage
`default_nettype wire

FILE: src/mfh_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfh_step: one-byte framing step
// Given the current framing state and the received byte, computes the next
// state and the result record for that byte.
// ---------------------------------------------------------------------------
module mfh_step import mfh_pkg::*; #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  mfh_state_t  cur,
	input  logic [7:0]  rx_byte,
	output mfh_state_t  nxt,
	output mfh_result_t res
);

	logic [LEN_W-1:0] group;
	logic [LEN_W-1:0] accum_new;
	logic [CNT_W-1:0] cnt_next;
	logic [LEN_W-1:0] pay_dec;
	logic             more;
	logic             too_long;
	logic             len_zero;
	logic             pay_end;
	logic             reserved;

	// place the 7-bit group at its position, least significant group first
	always_comb begin
		case (cur.length_byte_count[1:0])
			2'd0: group = {21'd0, rx_byte[6:0]};
			2'd1: group = {14'd0, rx_byte[6:0], 7'd0};
			2'd2: group = {7'd0, rx_byte[6:0], 14'd0};
			2'd3: group = {rx_byte[6:0], 21'd0};
			default: group = '0;
		endcase
	end

	assign accum_new = cur.length_accum | group;
	assign cnt_next  = cur.length_byte_count + CNT_W'(1);
	assign more      = rx_byte[7];
	assign too_long  = more && (cnt_next >= CNT_W'(MAX_LENGTH_BYTES));
	assign len_zero  = (accum_new == '0);
	assign pay_dec   = cur.payload_left - LEN_W'(1);
	assign pay_end   = (pay_dec == '0);
	assign reserved  = type_reserved(cur.type_flags[7:4]);

	function automatic mfh_state_t finish_packet(input logic resv);
		mfh_state_t s;
		s = STATE_RESET;
		if (resv) begin
			s.error = ERR_RESERVED;
			s.phase = PH_DISCARD;
		end
		return s;
	endfunction

	// next state
	always_comb begin
		nxt = cur;
		if (cur.error != ERR_NONE) begin
			nxt.phase = PH_DISCARD;
		end else begin
			unique case (cur.phase)
				PH_TYPE: begin
					nxt.type_flags        = rx_byte;
					nxt.length_accum      = '0;
					nxt.length_byte_count = '0;
					nxt.payload_left      = '0;
					nxt.phase             = PH_LEN;
				end
				PH_LEN: begin
					nxt.length_accum      = accum_new;
					nxt.length_byte_count = cnt_next;
					if (more) begin
						if (too_long) begin
							nxt.error = ERR_TOO_LONG;
							nxt.phase = PH_DISCARD;
						end
					end else if (len_zero) begin
						nxt = finish_packet(reserved);
					end else begin
						nxt.payload_left = accum_new;
						nxt.phase        = PH_PAY;
					end
				end
				PH_PAY: begin
					nxt.payload_left = pay_dec;
					if (pay_end) begin
						nxt = finish_packet(reserved);
					end
				end
				PH_DISCARD: begin
					nxt.phase = PH_DISCARD;
				end
				default: begin
					nxt.phase = PH_DISCARD;
				end
			endcase
		end
	end

	// per-byte result
	always_comb begin
		res.data_byte   = rx_byte;
		res.role        = ROLE_DISCARD;
		res.done        = 1'b0;
		res.type_flags  = 8'd0;
		res.length      = '0;
		res.header_size = '0;
		res.error       = nxt.error;
		if (cur.error == ERR_NONE) begin
			unique case (cur.phase)
				PH_TYPE: begin
					res.role        = ROLE_TYPE;
					res.type_flags  = rx_byte;
					res.header_size = HDR_W'(1);
				end
				PH_LEN: begin
					res.role        = ROLE_LEN;
					res.type_flags  = cur.type_flags;
					res.length      = accum_new;
					res.header_size = HDR_W'(1) + cnt_next;
					res.done        = !more && len_zero;
				end
				PH_PAY: begin
					res.role        = ROLE_PAY;
					res.type_flags  = cur.type_flags;
					res.length      = cur.length_accum;
					res.header_size = HDR_W'(1) + cur.length_byte_count;
					res.done        = pay_end;
				end
				PH_DISCARD: begin
					res.role = ROLE_DISCARD;
				end
				default: begin
					res.role = ROLE_DISCARD;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/mqtt_fixed_header_deframer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mqtt_fixed_header_deframer: mqtt control packet framer
// Frames a received byte stream into packets, decoding the type/flags byte
// and the remaining-length varint, and tags every byte with its role.
// ---------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_stall  rx_byte
//   out      out_valid/out_stall  data_byte, byte_role, packet_done,
//                                 packet_type, packet_flags,
//                                 remaining_length, header_size, fault_code
//
// one byte per cycle unless out_stall holds a result; each result is registered.
// the framing state update (length group merge, payload count down and
// zero compare) is combinational and feeds the state register.
// reset: expecting a type/flags byte, no error latched, output empty.
// in_stall is high while a result sits in the output register and
// out_stall is high; an error is held until reset.
// ---------------------------------------------------------------------------
module mqtt_fixed_header_deframer import mfh_pkg::*; #(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        data_byte,
	output logic [1:0]        byte_role,
	output logic              packet_done,
	output logic [3:0]        packet_type,
	output logic [3:0]        packet_flags,
	output logic [LEN_W-1:0]  remaining_length,
	output logic [HDR_W-1:0]  header_size,
	output logic [1:0]        fault_code
);

	mfh_state_t  state_q;
	mfh_state_t  state_nxt;
	mfh_result_t res_nxt;
	mfh_result_t res_s1;
	logic        valid_s1;
	logic        accept;

	mfh_step #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_step (
		.cur     (state_q),
		.rx_byte (rx_byte),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_nxt;
		end
	end

	assign out_valid        = valid_s1;
	assign data_byte        = res_s1.data_byte;
	assign byte_role        = res_s1.role;
	assign packet_done      = res_s1.done;
	assign packet_type      = res_s1.type_flags[7:4];
	assign packet_flags     = res_s1.type_flags[3:0];
	assign remaining_length = res_s1.length;
	assign header_size      = res_s1.header_size;
	assign fault_code       = res_s1.error;

	// a latched error never clears or changes
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.error != ERR_NONE) |=> (state_q.error == $past(state_q.error)))
		else $error("error latch changed after being set");

	// only a length or payload byte can complete a packet
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1.done) |->
		(res_s1.role == ROLE_LEN || res_s1.role == ROLE_PAY))
		else $error("packet end on a byte of the wrong role");

	// discarded bytes only follow a latched error
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1.role == ROLE_DISCARD) |-> (res_s1.error != ERR_NONE))
		else $error("byte discarded without an error");

	// every accepted request yields a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted byte produced no result");

endmodule
`default_nettype wire

FILE: tb/sv/tb_mqtt_fixed_header_deframer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_mqtt_fixed_header_deframer: self-checking bench for the packet framer
// Feeds whole mqtt packets with random headers, non-minimal length varints
// and random payloads. It ends each run on one sticky error case followed
// by discarded noise. Every byte's tagged result is checked against an
// in-bench framing predictor. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module tb_mqtt_fixed_header_deframer;
	import mfh_pkg::*;

	localparam int LIMIT_CYCLES   = 200000;
	localparam int MAX_SHOWN      = 10;
	localparam int RANDOM_BYTES   = 550;
	localparam int MAX_LEN_BYTES  = 4;
	localparam int IDLE_PCT       = 12;
	localparam int QUIET_FROM     = 250;
	localparam int QUIET_TO       = 500;

	typedef enum logic [1:0] {
		END_TOO_LONG,
		END_RESERVED_LO,
		END_RESERVED_HI
	} ending_t;

	typedef struct packed {
		logic [7:0]        data;
		role_t             role;
		logic              done;
		logic [3:0]        ptype;
		logic [3:0]        pflags;
		logic [LEN_W-1:0]  len;
		logic [HDR_W-1:0]  hsize;
		err_t              err;
	} byte_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte = 8'd0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        data_byte;
	logic [1:0]        byte_role;
	logic              packet_done;
	logic [3:0]        packet_type;
	logic [3:0]        packet_flags;
	logic [LEN_W-1:0]  remaining_length;
	logic [HDR_W-1:0]  header_size;
	logic [1:0]        fault_code;

	// bit 8 marks a request that waits until all results are back
	logic [8:0]        pending_bytes[$];
	byte_report_t      expected_reports[$];

	int                cycle_cnt = 0;
	int                mismatches = 0;
	int                bytes_checked = 0;
	int                packets_framed = 0;
	logic              req_taken = 1'b0;
	ending_t           ending;

	// framing predictor state
	phase_t            fr_phase = PH_TYPE;
	logic [7:0]        fr_tf = 8'd0;
	logic [LEN_W-1:0]  fr_len = '0;
	logic [2:0]        fr_cnt = '0;
	logic [LEN_W-1:0]  fr_left = '0;
	err_t              fr_err = ERR_NONE;

	always #4 clk = ~clk;

	mqtt_fixed_header_deframer #(
		.MAX_LENGTH_BYTES(MAX_LEN_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.byte_role(byte_role),
		.packet_done(packet_done),
		.packet_type(packet_type),
		.packet_flags(packet_flags),
		.remaining_length(remaining_length),
		.header_size(header_size),
		.fault_code(fault_code)
	);

	task automatic close_packet();
		packets_framed++;
		fr_err   = (fr_tf[7:4] == TYPE_RESERVED_LO || fr_tf[7:4] == TYPE_RESERVED_HI) ?
			ERR_RESERVED : ERR_NONE;
		fr_phase = (fr_err != ERR_NONE) ? PH_DISCARD : PH_TYPE;
		fr_tf    = 8'd0;
		fr_len   = '0;
		fr_cnt   = '0;
		fr_left  = '0;
	endtask

	task automatic frame_byte(input logic [7:0] b);
		byte_report_t r;
		logic [2:0]   grp;
		r = '{data: b, role: ROLE_DISCARD, done: 1'b0, ptype: 4'd0, pflags: 4'd0,
			len: '0, hsize: '0, err: ERR_NONE};
		if (fr_err != ERR_NONE || fr_phase == PH_DISCARD) begin
			fr_phase = PH_DISCARD;
		end else if (fr_phase == PH_TYPE) begin
			fr_tf    = b;
			fr_len   = '0;
			fr_cnt   = '0;
			fr_left  = '0;
			fr_phase = PH_LEN;
			r.role   = ROLE_TYPE;
			r.ptype  = b[7:4];
			r.pflags = b[3:0];
			r.hsize  = 3'd1;
		end else if (fr_phase == PH_LEN) begin
			grp      = (fr_cnt < 3'd4) ? fr_cnt : 3'd3;
			fr_len   = fr_len + (LEN_W'(b[6:0]) << (7 * grp));
			fr_cnt   = fr_cnt + 3'd1;
			r.role   = ROLE_LEN;
			r.ptype  = fr_tf[7:4];
			r.pflags = fr_tf[3:0];
			r.len    = fr_len;
			r.hsize  = fr_cnt + 3'd1;
			if (b[7]) begin
				if (fr_cnt >= MAX_LEN_BYTES) begin
					fr_err   = ERR_TOO_LONG;
					fr_phase = PH_DISCARD;
				end
			end else if (fr_len == '0) begin
				r.done = 1'b1;
				close_packet();
			end else begin
				fr_left  = fr_len;
				fr_phase = PH_PAY;
			end
		end else begin
			r.role   = ROLE_PAY;
			r.ptype  = fr_tf[7:4];
			r.pflags = fr_tf[3:0];
			r.len    = fr_len;
			r.hsize  = fr_cnt + 3'd1;
			fr_left  = fr_left - 1'b1;
			if (fr_left == '0) begin
				r.done = 1'b1;
				close_packet();
			end
		end
		r.err = fr_err;
		expected_reports.push_back(r);
	endtask

	task automatic add_byte(input logic [7:0] b, input logic hold);
		pending_bytes.push_back({hold, b});
	endtask

	// type byte, varint padded to nbytes groups, then random payload
	task automatic add_packet(input logic [7:0] tf, input int len, input int nbytes,
			input logic hold);
		add_byte(tf, hold);
		for (int i = 0; i < nbytes; i++) begin
			add_byte({(i < nbytes - 1), 7'((len >> (7 * i)) & 8'h7F)}, 1'b0);
		end
		for (int i = 0; i < len; i++) begin
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic note_mismatch(input byte_report_t want, input byte_report_t got,
			input logic orphan);
		if (mismatches < MAX_SHOWN) begin
			if (orphan) begin
				$display("mismatch: result with no request pending: byte %h role %0d",
					got.data, got.role);
			end else begin
				$display("mismatch at byte %0d:", bytes_checked);
				$display("  want data %h role %0d done %0d type %h flags %h len %h hdr %0d err %0d",
					want.data, want.role, want.done, want.ptype, want.pflags, want.len,
					want.hsize, want.err);
				$display("  got  data %h role %0d done %0d type %h flags %h len %h hdr %0d err %0d",
					got.data, got.role, got.done, got.ptype, got.pflags, got.len,
					got.hsize, got.err);
			end
		end
		mismatches++;
	endtask

	// monitor: checks results, records accepted requests
	always @(posedge clk) begin
		byte_report_t got;
		byte_report_t want;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("CHECK FAILED");
			$finish;
		end else if (arst_n) begin
			cycle_cnt <= cycle_cnt + 1;
			if (out_valid && !out_stall) begin
				got = '{data: data_byte, role: role_t'(byte_role), done: packet_done,
					ptype: packet_type, pflags: packet_flags, len: remaining_length,
					hsize: header_size, err: err_t'(fault_code)};
				if (expected_reports.size() == 0) begin
					note_mismatch(got, got, 1'b1);
				end else begin
					want = expected_reports.pop_front();
					if (got.data !== want.data || got.role !== want.role ||
							got.done !== want.done || got.ptype !== want.ptype ||
							got.pflags !== want.pflags || got.len !== want.len ||
							got.hsize !== want.hsize || got.err !== want.err) begin
						note_mismatch(want, got, 1'b0);
					end
				end
				bytes_checked++;
			end
			if (in_valid && !in_stall) begin
				frame_byte(rx_byte);
			end
			req_taken <= in_valid && !in_stall;
		end
	end

	// driver: new request or idle at the falling edge
	always @(negedge clk) begin
		logic quiet;
		quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
			if (!in_valid || req_taken) begin
				if (pending_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)
						&& !(pending_bytes[0][8] && expected_reports.size() != 0)) begin
					in_valid <= 1'b1;
					rx_byte  <= pending_bytes[0][7:0];
					void'(pending_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		int    len;
		int    nbytes;
		int    min_bytes;
		int    pick;
		logic  hold_set;
		logic [3:0] ptype;

		// short packets covering the header corners
		add_byte(8'h10, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h3F, 1'b0); add_byte(8'h01, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'hE0, 1'b0); add_byte(8'h02, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h80, 1'b0);
		// legal fourth length byte, zero length padded to four groups
		add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h2A, 1'b0); add_byte(8'h81, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'h00, 1'b0); add_byte(8'h55, 1'b0);
		add_byte(8'h1F, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0); add_byte(8'h00, 1'b0);

		hold_set = 1'b0;
		while (pending_bytes.size() < RANDOM_BYTES) begin
			ptype = 4'($urandom_range(1, 14));
			pick  = $urandom_range(0, 99);
			if (pick < 30) begin
				len = $urandom_range(0, 3);
			end else if (pick < 95) begin
				len = $urandom_range(4, 24);
			end else begin
				len = $urandom_range(128, 260);
			end
			min_bytes = (len < 128) ? 1 : 2;
			nbytes = min_bytes;
			if ($urandom_range(0, 3) == 0) begin
				nbytes = $urandom_range(min_bytes, MAX_LEN_BYTES);
			end
			add_packet({ptype, 4'($urandom_range(0, 15))}, len, nbytes,
				!hold_set && pending_bytes.size() >= RANDOM_BYTES / 2);
			if (pending_bytes.size() >= RANDOM_BYTES / 2) begin
				hold_set = 1'b1;
			end
		end

		// one sticky error per run, then noise that must be discarded
		ending = ending_t'($urandom_range(0, 2));
		if (ending == END_TOO_LONG) begin
			add_byte({4'($urandom_range(1, 14)), 4'($urandom_range(0, 15))}, 1'b0);
			for (int i = 0; i < MAX_LEN_BYTES; i++) begin
				add_byte(8'($urandom_range(0, 255)) | 8'h80, 1'b0);
			end
		end else begin
			ptype = (ending == END_RESERVED_LO) ? TYPE_RESERVED_LO : TYPE_RESERVED_HI;
			add_packet({ptype, 4'($urandom_range(0, 15))}, $urandom_range(0, 6),
				$urandom_range(1, MAX_LEN_BYTES), 1'b0);
		end
		pick = $urandom_range(24, 40);
		for (int i = 0; i < pick; i++) begin
			add_byte(8'($urandom_range(0, 255)), 1'b0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
		while (expected_reports.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0d results never arrived", expected_reports.size());
			mismatches++;
		end

		$display("checked %0d bytes in %0d packets over %0d cycles, %0d mismatches",
			bytes_checked, packets_framed, cycle_cnt, mismatches);
		$display("run closed on sticky error case %s", ending.name());
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
src/mfh_pkg.sv
src/mfh_step.sv
src/mqtt_fixed_header_deframer.sv
tb/sv/tb_mqtt_fixed_header_deframer.sv
